/* hw/rtl/tdfa_pkg.sv */
// Shared constants and types for the table-driven DFA recognizer.
// Used by tdfa_table and table_driven_dfa_recognizer_core; no dependencies.
package tdfa_pkg;

  // Automaton dimensions.
  localparam int NUM_STATES  = 16;
  localparam int SYMBOL_BITS = 8;

  // Field widths fixed by the interface.
  localparam int STATE_W  = 4;
  localparam int SYMBOL_W = 8;
  localparam int MODE_W   = 2;
  localparam int MASK_W   = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  // Transition table geometry: one entry per (state, symbol) pair.
  localparam int STATE_IDX_W = $clog2(NUM_STATES);
  localparam int TBL_ADDR_W  = STATE_IDX_W + SYMBOL_BITS;
  localparam int TBL_DEPTH   = NUM_STATES << SYMBOL_BITS;
  // Entry layout: valid bit over the next state.
  localparam int TBL_ENTRY_W = STATE_W + 1;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SYMBOL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_END    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_STATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FINAL_MASK  = 1'd1;

  // Write request into the transition table.
  typedef struct packed {
    logic                   en;
    logic [TBL_ADDR_W-1:0]  addr;
    logic [TBL_ENTRY_W-1:0] data;
  } tbl_wr_t;

endpackage

/* hw/rtl/tdfa_table.sv */
// Transition table memory: one write port and one synchronous read port.
// Depends on tdfa_pkg for geometry and the write request type.
module tdfa_table (
  input  logic                            clk_i,
  input  tdfa_pkg::tbl_wr_t               wr_i,
  input  logic                            rd_en_i,
  input  logic [tdfa_pkg::TBL_ADDR_W-1:0] rd_addr_i,
  output logic [tdfa_pkg::TBL_ENTRY_W-1:0] rd_data_o
);
  import tdfa_pkg::*;

  logic [TBL_ENTRY_W-1:0] mem [TBL_DEPTH];
  logic [TBL_ENTRY_W-1:0] rd_data_q;

  // Write port and registered read port; a read in the same cycle as a
  // write to the same entry returns the old contents.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/table_driven_dfa_recognizer_core.sv */
// Top level of the programmable DFA string recognizer.
// Depends on tdfa_pkg and instantiates the transition table tdfa_table.
//
// Every request is handled in turn: the cycle of the accepting edge reads the
// transition table entry, and the following cycle (busy high) uses the
// registered read data to update the state or write the table back, so a
// new request can be taken only after the previous one has left that cycle.
// This is set by the registered read of the table memory, which every symbol
// lookup needs before the next one can form its address.
// After reset the block sweeps the table to clear all valid bits, one entry
// per cycle over all 4096 entries, with busy high; configuration writes are taken
// during that sweep. An end-of-string request gives one result, shown for
// exactly one cycle with result_valid_o high, registered as its execute
// state ends; the receiver cannot stall it.
module table_driven_dfa_recognizer_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Request channel.
  input  logic                             start,
  output logic                             busy,
  input  logic [tdfa_pkg::MODE_W-1:0]      mode_i,
  input  logic [tdfa_pkg::STATE_W-1:0]     from_state_i,
  input  logic [tdfa_pkg::SYMBOL_W-1:0]    symbol_i,
  input  logic [tdfa_pkg::STATE_W-1:0]     to_state_i,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [tdfa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tdfa_pkg::CFG_W-1:0]       cfg_wdata_i,
  // Result channel.
  output logic                             result_valid_o,
  output logic                             accepted_o,
  output logic                             stuck_o,
  output logic [tdfa_pkg::STATE_W-1:0]     ending_state_o
);
  import tdfa_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                  state_q;
  logic [TBL_ADDR_W-1:0]   clr_cnt_q;
  logic [STATE_W-1:0]      start_state_q;
  logic [MASK_W-1:0]       final_mask_q;
  logic [STATE_W-1:0]      dfa_state_q;
  logic                    missing_q;
  logic                    result_valid_q;
  logic                    accepted_q;
  logic                    stuck_q;
  logic [STATE_W-1:0]      ending_state_q;

  // Request held during its execute cycle.
  logic [MODE_W-1:0]       item_mode_q;
  logic [STATE_W-1:0]      item_to_q;
  logic [TBL_ADDR_W-1:0]   item_addr_q;
  logic                    item_wr_ok_q;

  logic                    req_accept;
  logic [STATE_W-1:0]      addr_state;
  logic [TBL_ADDR_W-1:0]   rd_addr;
  logic                    wr_in_range;
  logic                    cur_in_range;
  logic [TBL_ENTRY_W-1:0]  rd_data;
  logic                    rd_valid;
  logic [STATE_W-1:0]      rd_next;
  tbl_wr_t                 tbl_wr;

  assign busy       = (state_q != ST_IDLE);
  assign req_accept = start && !busy;

  // Table address: the written source state for transition writes, the
  // current state for lookups.
  assign addr_state = (mode_i == MODE_WRITE) ? from_state_i : dfa_state_q;
  assign rd_addr    = {addr_state[STATE_IDX_W-1:0], symbol_i[SYMBOL_BITS-1:0]};

  assign wr_in_range  = (int'(from_state_i) < NUM_STATES) &&
                        (int'(to_state_i) < NUM_STATES);
  assign cur_in_range = (int'(dfa_state_q) < NUM_STATES);

  assign rd_valid = rd_data[TBL_ENTRY_W-1];
  assign rd_next  = rd_data[STATE_W-1:0];

  // Table write: the clearing sweep after reset, otherwise the write-back of
  // a transition whose pair is not yet defined.
  always_comb begin
    tbl_wr = '0;
    if (state_q == ST_CLEAR) begin
      tbl_wr.en   = 1'b1;
      tbl_wr.addr = clr_cnt_q;
      tbl_wr.data = '0;
    end else if (state_q == ST_EXEC && item_mode_q == MODE_WRITE &&
                 item_wr_ok_q && !rd_valid) begin
      tbl_wr.en   = 1'b1;
      tbl_wr.addr = item_addr_q;
      tbl_wr.data = {1'b1, item_to_q};
    end
  end

  tdfa_table u_table (
    .clk_i     (clk_i),
    .wr_i      (tbl_wr),
    .rd_en_i   (req_accept),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Request payload latched at the accepting edge.
  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      item_mode_q  <= mode_i;
      item_to_q    <= to_state_i;
      item_addr_q  <= rd_addr;
      item_wr_ok_q <= wr_in_range;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC && item_mode_q == MODE_END) begin
      accepted_q     <= !missing_q && final_mask_q[dfa_state_q];
      stuck_q        <= missing_q;
      ending_state_q <= dfa_state_q;
    end
  end

  // Sequencer, automaton state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_cnt_q      <= '0;
      start_state_q  <= '0;
      final_mask_q   <= '0;
      dfa_state_q    <= '0;
      missing_q      <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == TBL_ADDR_W'(TBL_DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q <= ST_IDLE;
          case (item_mode_q)
            MODE_SYMBOL: begin
              if (!missing_q) begin
                if (cur_in_range && rd_valid) begin
                  dfa_state_q <= rd_next;
                end else begin
                  missing_q <= 1'b1;
                end
              end
            end
            MODE_END: begin
              result_valid_q <= 1'b1;
              dfa_state_q    <= start_state_q;
              missing_q      <= 1'b0;
            end
            default: begin
              // Transition writes act through the table port; mode 3 is ignored.
            end
          endcase
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      // Configuration writes; a start state write abandons the current string.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_START_STATE: begin
            start_state_q <= cfg_wdata_i[STATE_W-1:0];
            dfa_state_q   <= cfg_wdata_i[STATE_W-1:0];
            missing_q     <= 1'b0;
          end
          REG_FINAL_MASK: begin
            final_mask_q <= cfg_wdata_i[MASK_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign result_valid_o = result_valid_q;
  assign accepted_o     = accepted_q;
  assign stuck_o        = stuck_q;
  assign ending_state_o = ending_state_q;

endmodule

/* tb/tb_table_driven_dfa_recognizer_core.sv */
// Self-checking testbench for table_driven_dfa_recognizer_core.
// Depends on tdfa_pkg and the core; drives directed and random requests and
// checks every end-of-string verdict against a local model of the automaton.
module tb_table_driven_dfa_recognizer_core;
  import tdfa_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int SYM_MASK      = (1 << SYMBOL_BITS) - 1;
  localparam int ITEM_TARGET   = 1700;
  localparam int PHASE_ITEMS   = 280;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_PRINTS    = 50;

  // One end-of-string verdict as the block reports it.
  typedef struct packed {
    logic                accepted;
    logic                stuck;
    logic [STATE_W-1:0]  ending_state;
  } verdict_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [MODE_W-1:0]    mode_i = MODE_WRITE;
  logic [STATE_W-1:0]   from_state_i = '0;
  logic [SYMBOL_W-1:0]  symbol_i = '0;
  logic [STATE_W-1:0]   to_state_i = '0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_START_STATE;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 result_valid_o;
  logic                 accepted_o;
  logic                 stuck_o;
  logic [STATE_W-1:0]   ending_state_o;

  // Local copy of the automaton: transition table, registers and string state.
  logic [STATE_W-1:0]   next_state_mem [TBL_DEPTH];
  bit                   valid_mem [TBL_DEPTH];
  logic [STATE_W-1:0]   model_state = '0;
  bit                   miss_flag = 1'b0;
  logic [STATE_W-1:0]   start_reg = '0;
  logic [MASK_W-1:0]    mask_reg = '0;

  verdict_t pending_verdicts [$];
  verdict_t seen_v;
  verdict_t due_v;
  int       items_sent = 0;
  int       mismatch_count = 0;
  int       cycle_count = 0;

  table_driven_dfa_recognizer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .from_state_i   (from_state_i),
    .symbol_i       (symbol_i),
    .to_state_i     (to_state_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .accepted_o     (accepted_o),
    .stuck_o        (stuck_o),
    .ending_state_o (ending_state_o)
  );

  // Clock with a period of 8.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Prints one line per mismatch (up to a cap) and counts all of them.
  task automatic flag_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
    mismatch_count++;
  endtask

  // Table address of a (state, symbol) pair; only the low symbol bits count.
  function automatic int tbl_ix(input logic [STATE_W-1:0] st,
                                input logic [SYMBOL_W-1:0] sym);
    return (int'(st) << SYMBOL_BITS) | (int'(sym) & SYM_MASK);
  endfunction

  // Advances the local automaton by one accepted request.
  function automatic void dfa_step(input logic [MODE_W-1:0] md,
                                   input logic [STATE_W-1:0] src,
                                   input logic [SYMBOL_W-1:0] sym,
                                   input logic [STATE_W-1:0] dst);
    int       ix;
    verdict_t v;
    case (md)
      MODE_WRITE: begin
        // The first write to a pair wins; later ones are dropped.
        if (int'(src) < NUM_STATES && int'(dst) < NUM_STATES) begin
          ix = tbl_ix(src, sym);
          if (!valid_mem[ix]) begin
            valid_mem[ix] = 1'b1;
            next_state_mem[ix] = dst;
          end
        end
      end
      MODE_SYMBOL: begin
        // Once a transition is missing, the rest of the string is ignored.
        if (!miss_flag) begin
          if (int'(model_state) < NUM_STATES) begin
            ix = tbl_ix(model_state, sym);
            if (valid_mem[ix]) begin
              model_state = next_state_mem[ix];
            end else begin
              miss_flag = 1'b1;
            end
          end else begin
            miss_flag = 1'b1;
          end
        end
      end
      MODE_END: begin
        v.accepted = !miss_flag && mask_reg[model_state];
        v.stuck = miss_flag;
        v.ending_state = model_state;
        pending_verdicts.insert(pending_verdicts.size(), v);
        model_state = start_reg;
        miss_flag = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  // Compares each result with the oldest pending verdict.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      seen_v = '{accepted_o, stuck_o, ending_state_o};
      if (pending_verdicts.size() == 0) begin
        flag_mismatch("result with no end-of-string request pending");
      end else begin
        due_v = pending_verdicts.pop_front();
        if (seen_v.accepted !== due_v.accepted)
          flag_mismatch($sformatf("accepted %b, want %b", seen_v.accepted, due_v.accepted));
        if (seen_v.stuck !== due_v.stuck)
          flag_mismatch($sformatf("stuck %b, want %b", seen_v.stuck, due_v.stuck));
        if (seen_v.ending_state !== due_v.ending_state)
          flag_mismatch($sformatf("ending_state %0d, want %0d",
                                  seen_v.ending_state, due_v.ending_state));
      end
    end
  end

  // Holds start low while the sender stays idle.
  task automatic idle_sender(input int n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  // Mostly short gaps, a few long ones; none inside a burst.
  function automatic int pick_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Sends one request and waits until the block takes it.
  task automatic issue_request(input logic [MODE_W-1:0] md,
                               input logic [STATE_W-1:0] src,
                               input logic [SYMBOL_W-1:0] sym,
                               input logic [STATE_W-1:0] dst,
                               input int gap);
    if (gap > 0) idle_sender(gap);
    @(negedge clk_i);
    start <= 1'b1;
    mode_i <= md;
    from_state_i <= src;
    symbol_i <= sym;
    to_state_i <= dst;
    do @(posedge clk_i); while (busy);
    dfa_step(md, src, sym, dst);
    items_sent++;
  endtask

  // Stops sending and waits for every pending verdict plus the block's latency.
  task automatic wait_for_results();
    idle_sender(1);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes one configuration register once the block has gone quiet.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    wait_for_results();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_START_STATE) begin
      // A new start state also abandons the string in progress.
      start_reg = data[STATE_W-1:0];
      model_state = start_reg;
      miss_flag = 1'b0;
    end else begin
      mask_reg = data[MASK_W-1:0];
    end
  endtask

  // Table loading, duplicate writes, accepting and rejecting strings.
  task automatic test_table_basics();
    write_reg(REG_FINAL_MASK, 16'h8001);
    write_reg(REG_START_STATE, 16'h0000);
    issue_request(MODE_WRITE, 4'd0, 8'h00, 4'd1, pick_gap(0));
    issue_request(MODE_WRITE, 4'd1, 8'hFF, 4'd15, pick_gap(0));
    issue_request(MODE_WRITE, 4'd15, 8'hA5, 4'd0, pick_gap(0));
    // A second write to a defined pair must not change it.
    issue_request(MODE_WRITE, 4'd0, 8'h00, 4'd7, pick_gap(0));
    issue_request(MODE_END, 4'd15, 8'hFF, 4'd15, pick_gap(0));
    issue_request(MODE_SYMBOL, 4'd0, 8'h00, 4'd0, 0);
    issue_request(MODE_SYMBOL, 4'd15, 8'hFF, 4'd15, 0);
    issue_request(MODE_END, 4'd0, 8'h00, 4'd0, 0);
    issue_request(MODE_SYMBOL, 4'd0, 8'h00, 4'd0, pick_gap(0));
    issue_request(MODE_END, 4'd0, 8'h00, 4'd0, pick_gap(0));
    // The unused mode gives no result.
    issue_request(MODE_UNUSED, 4'd15, 8'hFF, 4'd15, pick_gap(0));
  endtask

  // Missing transitions, the sticky flag and table writes mid-string.
  task automatic test_reject_paths();
    issue_request(MODE_SYMBOL, 4'd0, 8'h42, 4'd0, pick_gap(0));
    issue_request(MODE_SYMBOL, 4'd0, 8'h00, 4'd0, pick_gap(0));
    issue_request(MODE_END, 4'd0, 8'h00, 4'd0, pick_gap(0));
    issue_request(MODE_SYMBOL, 4'd0, 8'h00, 4'd0, 0);
    issue_request(MODE_WRITE, 4'd1, 8'h42, 4'd0, 0);
    issue_request(MODE_SYMBOL, 4'd0, 8'h42, 4'd0, 0);
    issue_request(MODE_END, 4'd0, 8'h00, 4'd0, 0);
  endtask

  // Start state reload, including a write that abandons a string.
  task automatic test_start_reload();
    // Upper data bits beyond the register width are dropped.
    write_reg(REG_START_STATE, 16'hFFF1);
    issue_request(MODE_SYMBOL, 4'd0, 8'h00, 4'd0, pick_gap(0));
    issue_request(MODE_END, 4'd0, 8'h00, 4'd0, pick_gap(0));
    issue_request(MODE_SYMBOL, 4'd0, 8'hFF, 4'd0, pick_gap(0));
    write_reg(REG_START_STATE, 16'h000F);
    issue_request(MODE_SYMBOL, 4'd0, 8'hA5, 4'd0, pick_gap(0));
    issue_request(MODE_END, 4'd0, 8'h00, 4'd0, pick_gap(0));
    write_reg(REG_FINAL_MASK, 16'h0000);
    issue_request(MODE_END, 4'd0, 8'h00, 4'd0, pick_gap(0));
    write_reg(REG_FINAL_MASK, 16'hFFFF);
    issue_request(MODE_END, 4'd0, 8'h00, 4'd0, pick_gap(0));
  endtask

  // Random strings, mostly along defined transitions, over several settings.
  task automatic test_random_strings();
    logic [SYMBOL_W-1:0] alphabet [4];
    logic [SYMBOL_W-1:0] sym;
    int                  len;
    int                  phase;
    int                  phase_end;
    bit                  burst;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      // Extremes first, then random settings with junk in the unused bits.
      case (phase)
        0: begin
          write_reg(REG_START_STATE, 16'h0000);
          write_reg(REG_FINAL_MASK, 16'h0000);
        end
        1: begin
          write_reg(REG_START_STATE, 16'h000F);
          write_reg(REG_FINAL_MASK, 16'hFFFF);
        end
        default: begin
          write_reg(REG_START_STATE, CFG_W'($urandom));
          write_reg(REG_FINAL_MASK, CFG_W'($urandom));
        end
      endcase
      for (int a = 0; a < 4; a++) alphabet[a] = SYMBOL_W'($urandom);
      if (phase == 1) begin
        alphabet[0] = 8'h00;
        alphabet[1] = 8'hFF;
      end
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
        burst = ($urandom_range(0, 3) == 0);
        len = $urandom_range(0, 10);
        for (int k = 0; k < len; k++) begin
          sym = ($urandom_range(0, 9) == 0) ? SYMBOL_W'($urandom)
                                            : alphabet[$urandom_range(0, 3)];
          // Usually define the next transition so the string keeps going.
          if (!miss_flag && !valid_mem[tbl_ix(model_state, sym)] &&
              $urandom_range(0, 99) < 85) begin
            issue_request(MODE_WRITE, model_state, sym, STATE_W'($urandom),
                          pick_gap(burst));
          end
          // Occasional noise: a stray write or an unused mode.
          if ($urandom_range(0, 19) == 0) begin
            issue_request($urandom_range(0, 1) ? MODE_WRITE : MODE_UNUSED,
                          STATE_W'($urandom), SYMBOL_W'($urandom), STATE_W'($urandom),
                          pick_gap(burst));
          end
          issue_request(MODE_SYMBOL, STATE_W'($urandom), sym, STATE_W'($urandom),
                        pick_gap(burst));
        end
        issue_request(MODE_END, STATE_W'($urandom), SYMBOL_W'($urandom),
                      STATE_W'($urandom), pick_gap(burst));
        if ($urandom_range(0, 29) == 0) wait_for_results();
      end
      phase++;
    end
  endtask

  // Reset once, run the tests in turn, then drain and report.
  initial begin
    for (int i = 0; i < TBL_DEPTH; i++) valid_mem[i] = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_table_basics();
    test_reject_paths();
    test_start_reload();
    test_random_strings();
    wait_for_results();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
